[src/assert_macros.svh]
// assertion helpers, compiled out when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define NSPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// expression must never be true outside reset
`define NSPE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define NSPE_ASSERT(lbl, prop, msg)
`define NSPE_NEVER(lbl, expr, msg)
`endif
`endif

[src/nspe_pkg.sv]
package nspe_pkg;

  localparam int QW     = 32;
  localparam int DVD_W  = 49;
  localparam int DVS_W  = 33;
  localparam int SAT_W  = 66;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_U_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V_ORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_U_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_V_COUNT = 2'd3;

  localparam logic signed [QW-1:0] Q_ONE = 32'sd65536;

  typedef enum logic [1:0] {
    CMD_WR_UKNOT = 2'd0,
    CMD_WR_VKNOT = 2'd1,
    CMD_WR_POINT = 2'd2,
    CMD_EVAL     = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE, S_PT_MUL, S_PT_WR, S_SPAN_RD, S_SPAN_CMP, S_ROW_LD, S_CARRY,
    S_KLO, S_KHI, S_ALPHA, S_ALPHA_W, S_BLEND, S_DBEND, S_COPY, S_FIN,
    S_FIN_DIV, S_FIN_W, S_DONE
  } state_e;

  // homogeneous point, element 0..2 = x,y,z times weight, element 3 = weight
  typedef logic [3:0][QW-1:0] hpt_t;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [QW-1:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[QW-1:0];
    return r;
  endfunction

endpackage

[src/nspe_if.sv]
interface nspe_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [4:0]         index_u;
  logic [4:0]         index_v;
  logic signed [31:0] knot_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] point_weight;
  logic signed [31:0] param_u;
  logic signed [31:0] param_v;

  modport source (output valid, command, index_u, index_v, knot_value, point_x, point_y,
                  point_z, point_weight, param_u, param_v, input ready);
  modport sink (input valid, command, index_u, index_v, knot_value, point_x, point_y,
                point_z, point_weight, param_u, param_v, output ready);
endinterface

interface nspe_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] surf_x;
  logic signed [31:0] surf_y;
  logic signed [31:0] surf_z;
  logic               zero_weight;

  modport source (output valid, surf_x, surf_y, surf_z, zero_weight, input ready);
  modport sink (input valid, surf_x, surf_y, surf_z, zero_weight, output ready);
endinterface

[src/nurbs_surface_point_eval_core.sv]
// rational b-spline surface point evaluator, q16.16 fixed point
// knot write: goes straight to the knot ram; point write: three products on the shared multiplier
// evaluate: span search reads and tests one knot at a time, then each de boor step does
//   two knot reads, an alpha divide on the bit-serial divider unless the knot difference is zero
//   and eight products on the multiplier, with order k steps = k*k*(k-1)/2 + k*(k-1)/2
// async active-low reset clears control and sets orders and counts to 4; stores are not cleared
`include "assert_macros.svh"

module nurbs_surface_point_eval_core import nspe_pkg::*; #(
  parameter int MAX_POINTS = 16,
  parameter int MAX_ORDER  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  nspe_req_if.sink              req_i,
  nspe_rsp_if.source            rsp_o
);

  localparam int KD = MAX_POINTS + MAX_ORDER;
  localparam int KW = $clog2(KD);
  localparam int IW = $clog2(KD + 1);
  localparam int GD = MAX_POINTS * MAX_POINTS;
  localparam int GW = $clog2(GD);
  localparam int OW = $clog2(MAX_ORDER);
  localparam int MW = $clog2(((MAX_ORDER > 8) ? MAX_ORDER : 8) + 1);
  localparam int HW = 4 * QW;

  // config registers
  logic [2:0] u_order_q, v_order_q;
  logic [4:0] u_count_q, v_count_q;

  state_e state_q, state_d;

  // item registers
  hpt_t                 pt_q;
  logic                 pt_ok_q;
  logic [GW-1:0]        pt_addr_q;
  logic signed [QW-1:0] pu_x_q, pv_x_q;
  logic [IW-1:0]        pu_q, pv_q, uc_q, vc_q, su_q, sv_q;

  // sequencing
  logic [IW-1:0] i_q, r_q, j_q, row_q;
  logic [MW-1:0] m_q, mm;
  logic          dir_q;

  // datapath
  logic signed [QW-1:0] lo_q, a_q, b_q;
  hpt_t                 cur_q, carry_q;
  hpt_t                 w_q [MAX_ORDER];
  hpt_t                 col_q [MAX_ORDER];
  logic signed [63:0]   prod_q, acc_q;
  logic                 zw_q;

  // result register
  logic                 out_valid_q;
  logic signed [QW-1:0] out_x_q, out_y_q, out_z_q;
  logic                 out_zw_q;

  // ram and unit connections
  logic                 uk_we, vk_we, g_we;
  logic [KW-1:0]        kwaddr_u, kwaddr_v, kn_raddr;
  logic [GW-1:0]        gr_raddr;
  logic [QW-1:0]        uk_rd, vk_rd;
  logic [HW-1:0]        gr_rd;
  logic signed [QW-1:0] kn_rd, x_s;
  logic signed [QW-1:0] mul_a, mul_b;
  logic                 div_start, div_busy, div_done;
  logic signed [DVD_W-1:0] div_dvd;
  logic signed [DVS_W-1:0] div_dvs;
  logic signed [QW-1:0] div_quot;
  logic signed [DVS_W-1:0] den;

  logic          req_acc;
  logic [IW-1:0] p_s, sp_s, cnt_s;
  logic [IW-1:0] uo_c, vo_c, uc_c, vc_c;
  logic          span_hit;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // active direction: u while building rows, v across them
  assign p_s   = dir_q ? pv_q : pu_q;
  assign sp_s  = dir_q ? sv_q : su_q;
  assign cnt_s = dir_q ? vc_q : uc_q;
  assign x_s   = dir_q ? pv_x_q : pu_x_q;
  assign kn_rd = dir_q ? vk_rd : uk_rd;
  assign den   = DVS_W'(kn_rd) - DVS_W'(lo_q);
  assign mm    = m_q - 1'b1;
  assign span_hit = x_s < kn_rd;

  // out-of-range registers are clamped when an evaluate arrives
  assign uo_c = (u_order_q < 3'd2) ? IW'(2) :
                (32'(u_order_q) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(u_order_q);
  assign vo_c = (v_order_q < 3'd2) ? IW'(2) :
                (32'(v_order_q) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(v_order_q);
  assign uc_c = (32'(u_count_q) < 32'(uo_c)) ? uo_c :
                (32'(u_count_q) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(u_count_q);
  assign vc_c = (32'(v_count_q) < 32'(vo_c)) ? vo_c :
                (32'(v_count_q) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(v_count_q);

  // knot writes go straight to the knot rams on transfer
  assign uk_we    = req_acc && (cmd_e'(req_i.command) == CMD_WR_UKNOT) &&
                    (32'(req_i.index_u) < KD);
  assign vk_we    = req_acc && (cmd_e'(req_i.command) == CMD_WR_VKNOT) &&
                    (32'(req_i.index_v) < KD);
  assign kwaddr_u = KW'(req_i.index_u);
  assign kwaddr_v = KW'(req_i.index_v);

  nspe_ram #(.WIDTH(QW), .DEPTH(KD)) u_uknot_ram (
    .clk_i   (clk_i),
    .we_i    (uk_we),
    .waddr_i (kwaddr_u),
    .wdata_i (req_i.knot_value),
    .raddr_i (kn_raddr),
    .rdata_o (uk_rd)
  );

  nspe_ram #(.WIDTH(QW), .DEPTH(KD)) u_vknot_ram (
    .clk_i   (clk_i),
    .we_i    (vk_we),
    .waddr_i (kwaddr_v),
    .wdata_i (req_i.knot_value),
    .raddr_i (kn_raddr),
    .rdata_o (vk_rd)
  );

  // control grid, weight-premultiplied points
  nspe_ram #(.WIDTH(HW), .DEPTH(GD)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (pt_addr_q),
    .wdata_i (pt_q),
    .raddr_i (gr_raddr),
    .rdata_o (gr_rd)
  );

  // shared divider for alpha and the final perspective divide
  nspe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_order_q <= 3'd4;
      v_order_q <= 3'd4;
      u_count_q <= 5'd4;
      v_count_q <= 5'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_U_ORDER: u_order_q <= cfg_wdata_i[2:0];
        CFG_V_ORDER: v_order_q <= cfg_wdata_i[2:0];
        CFG_U_COUNT: u_count_q <= cfg_wdata_i;
        CFG_V_COUNT: v_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // next state, ram addresses and unit operands
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    kn_raddr  = '0;
    g_we      = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    gr_raddr  = GW'(32'(sv_q - pv_q + row_q) * MAX_POINTS +
                    32'(su_q - pu_q + IW'(m_q)));
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          case (cmd_e'(req_i.command))
            CMD_WR_POINT: state_d = S_PT_MUL;
            CMD_EVAL:     state_d = S_SPAN_RD;
            default: ;
          endcase
        end
      end
      S_PT_MUL: begin
        mul_a = pt_q[m_q[1:0]];
        mul_b = pt_q[3];
        if (m_q == MW'(3)) state_d = S_PT_WR;
      end
      S_PT_WR: begin
        g_we    = pt_ok_q;
        state_d = S_IDLE;
      end
      S_SPAN_RD: begin
        kn_raddr = KW'(i_q);
        if (i_q >= cnt_s) begin
          if (dir_q) state_d = S_ROW_LD;
        end else begin
          state_d = S_SPAN_CMP;
        end
      end
      S_SPAN_CMP: begin
        if (span_hit && dir_q) state_d = S_ROW_LD;
        else state_d = S_SPAN_RD;
      end
      S_ROW_LD: begin
        if (32'(m_q) == 32'(pu_q) + 1) state_d = S_CARRY;
      end
      S_CARRY: state_d = S_KLO;
      S_KLO: begin
        kn_raddr = KW'(sp_s - p_s + j_q);
        state_d  = S_KHI;
      end
      S_KHI: begin
        kn_raddr = KW'(sp_s + j_q + 1'b1 - r_q);
        state_d  = S_ALPHA;
      end
      S_ALPHA: begin
        if (den != '0) begin
          div_start = 1'b1;
          div_dvd   = {DVS_W'(x_s) - DVS_W'(lo_q), 16'h0};
          div_dvs   = den;
          state_d   = S_ALPHA_W;
        end else begin
          state_d = S_BLEND;
        end
      end
      S_ALPHA_W: begin
        if (div_done) state_d = S_BLEND;
      end
      S_BLEND: begin
        // even slots: left point times (1 - alpha), odd slots: right point times alpha
        if (!m_q[0]) begin
          mul_a = cur_q[m_q[2:1]];
          mul_b = b_q;
        end else begin
          mul_a = carry_q[m_q[2:1]];
          mul_b = a_q;
        end
        if (m_q == MW'(8)) begin
          if (j_q == r_q) begin
            state_d = (r_q == p_s) ? S_DBEND : S_CARRY;
          end else begin
            state_d = S_KLO;
          end
        end
      end
      S_DBEND: begin
        if (dir_q) state_d = S_FIN;
        else if (row_q == pv_q) state_d = S_COPY;
        else state_d = S_ROW_LD;
      end
      S_COPY: begin
        if (IW'(m_q) == pv_q) state_d = S_CARRY;
      end
      S_FIN: begin
        state_d = (cur_q[3] == '0) ? S_DONE : S_FIN_DIV;
      end
      S_FIN_DIV: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'($signed({cur_q[m_q[1:0]], 16'h0}));
        div_dvs   = DVS_W'($signed(cur_q[3]));
        state_d   = S_FIN_W;
      end
      S_FIN_W: begin
        if (div_done) state_d = (m_q == MW'(2)) ? S_DONE : S_FIN_DIV;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          pt_q      <= {req_i.point_weight, req_i.point_z, req_i.point_y, req_i.point_x};
          pt_ok_q   <= (32'(req_i.index_u) < MAX_POINTS) && (32'(req_i.index_v) < MAX_POINTS);
          pt_addr_q <= GW'(32'(req_i.index_v) * MAX_POINTS + 32'(req_i.index_u));
          pu_x_q    <= req_i.param_u;
          pv_x_q    <= req_i.param_v;
          pu_q      <= uo_c - 1'b1;
          pv_q      <= vo_c - 1'b1;
          uc_q      <= uc_c;
          vc_q      <= vc_c;
          i_q       <= uo_c;
          dir_q     <= 1'b0;
          m_q       <= '0;
        end
      end
      S_PT_MUL: begin
        m_q <= m_q + 1'b1;
        if (m_q != '0) pt_q[m_q[1:0] - 2'd1] <= sat_q(SAT_W'(prod_q >>> 16));
      end
      S_SPAN_RD, S_SPAN_CMP: begin
        if ((state_q == S_SPAN_RD && i_q >= cnt_s) || (state_q == S_SPAN_CMP && span_hit)) begin
          if (dir_q) sv_q <= (state_q == S_SPAN_RD) ? cnt_s - 1'b1 : i_q - 1'b1;
          else su_q <= (state_q == S_SPAN_RD) ? cnt_s - 1'b1 : i_q - 1'b1;
          if (!dir_q) begin
            dir_q <= 1'b1;
            i_q   <= pv_q + 1'b1;
          end else begin
            dir_q <= 1'b0;
            row_q <= '0;
            m_q   <= '0;
          end
        end else if (state_q == S_SPAN_CMP) begin
          i_q <= i_q + 1'b1;
        end
      end
      S_ROW_LD: begin
        m_q <= m_q + 1'b1;
        if (m_q != '0) w_q[OW'(mm)] <= gr_rd;
        r_q <= IW'(1);
      end
      S_CARRY: begin
        carry_q <= w_q[OW'(p_s)];
        j_q     <= p_s;
      end
      S_KLO: cur_q <= w_q[OW'(j_q - 1'b1)];
      S_KHI: lo_q <= kn_rd;
      S_ALPHA: begin
        m_q <= '0;
        if (den == '0) begin
          a_q <= '0;
          b_q <= Q_ONE;
        end
      end
      S_ALPHA_W: begin
        if (div_done) begin
          a_q <= div_quot;
          b_q <= sat_q(SAT_W'(34'sd65536 - 34'(div_quot)));
        end
      end
      S_BLEND: begin
        m_q <= m_q + 1'b1;
        if (m_q != '0) begin
          if (!mm[0]) acc_q <= prod_q;
          else w_q[OW'(j_q)][mm[2:1]] <= sat_q(SAT_W'((65'(acc_q) + 65'(prod_q)) >>> 16));
        end
        if (m_q == MW'(8)) begin
          carry_q <= cur_q;
          if (j_q == r_q) r_q <= r_q + 1'b1;
          else j_q <= j_q - 1'b1;
        end
      end
      S_DBEND: begin
        m_q <= '0;
        if (dir_q) begin
          cur_q <= w_q[OW'(pv_q)];
        end else begin
          col_q[OW'(row_q)] <= w_q[OW'(pu_q)];
          if (row_q == pv_q) dir_q <= 1'b1;
          else row_q <= row_q + 1'b1;
        end
      end
      S_COPY: begin
        w_q[OW'(m_q)] <= col_q[OW'(m_q)];
        m_q <= m_q + 1'b1;
        r_q <= IW'(1);
      end
      S_FIN: begin
        m_q <= '0;
        if (cur_q[3] == '0) begin
          cur_q[0] <= '0;
          cur_q[1] <= '0;
          cur_q[2] <= '0;
          zw_q     <= 1'b1;
        end else begin
          zw_q <= 1'b0;
        end
      end
      S_FIN_W: begin
        if (div_done) begin
          cur_q[m_q[1:0]] <= div_quot;
          m_q <= m_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_x_q  <= cur_q[0];
          out_y_q  <= cur_q[1];
          out_z_q  <= cur_q[2];
          out_zw_q <= zw_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.surf_x      = out_x_q;
  assign rsp_o.surf_y      = out_y_q;
  assign rsp_o.surf_z      = out_z_q;
  assign rsp_o.zero_weight = out_zw_q;

  // the divider is only ever in use inside an evaluate
  `NSPE_ASSERT(a_idle_div_free, req_i.ready |-> !div_busy, "divider busy while accepting")
  `NSPE_NEVER(a_div_restart, div_start && div_busy, "divider started while busy")
  `NSPE_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q) == S_DONE, "result without done")

endmodule

[src/nspe_ram.sv]
module nspe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/nspe_div.sv]
module nspe_div import nspe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic signed [DVS_W-1:0] divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [QW-1:0]    quot_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q, neg_q;
  logic [DVS_W-1:0]     dvs_q, rem_q, rem_d;
  logic [DVD_W-1:0]     quo_q;
  logic signed [QW-1:0] quot_q;
  logic [DVS_W:0]       shifted;
  logic                 ge;

  // restoring division on magnitudes, one quotient bit a cycle
  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign rem_d   = ge ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      neg_q <= dividend_i[DVD_W-1] ^ divisor_i[DVS_W-1];
      quo_q <= dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
      dvs_q <= divisor_i[DVS_W-1] ? DVS_W'(-divisor_i) : DVS_W'(divisor_i);
      rem_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        // sign and saturate
        if (!neg_q) begin
          quot_q <= (quo_q > DVD_W'(64'd2147483647)) ? 32'sh7fffffff : quo_q[QW-1:0];
        end else begin
          quot_q <= (quo_q > DVD_W'(64'd2147483648)) ? 32'sh80000000
                                                    : QW'(~quo_q + 1'b1);
        end
      end else begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DVD_W-2:0], ge};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
